// File: src/tpdr_pkg.sv
// Shared constants and types for the tach period / duty regulator.
// No dependencies; imported by tach_period_duty_regulator_top.
`timescale 1ns / 1ps
`default_nettype none
package tpdr_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int PERIOD_W   = 10;
  localparam int DUTY_W     = 10;
  localparam int TICKS_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  localparam int FULL_SCALE_DEF = 1000;
  localparam int STEP_DEF       = 1;
  localparam int KICK_STEPS     = 10;

  localparam logic [TICKS_W-1:0]  TIMEOUT_TICKS     = 10'd1000;
  localparam logic [DUTY_W-1:0]   DUTY_MAX          = 10'd1023;
  localparam logic [DUTY_W-1:0]   DUTY_RESET        = 10'd400;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET   = 12'h4B0;
  localparam logic [PERIOD_W-1:0] TARGET_RESET      = 10'd150;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PERIOD    = 2'd1;

  typedef struct packed {
    logic              stall_kick;
    logic              mark_seen;
    logic [DUTY_W-1:0] duty;
  } tpdr_result_t;

endpackage
`default_nettype wire

// File: src/tach_period_duty_regulator_top.sv
// Tach period / duty regulator: mark detection, period compare, duty update.
// Depends on tpdr_pkg.
//
// Usage:
//   in_*  : one sensor sample per transfer, in_tdata[11:0] = sample.
//   out_* : one result per input transfer, out_tdata[9:0] = duty,
//           out_tuser[0] = mark_seen, out_tuser[1] = stall_kick.
//   cfg_* : register writes; index 0 = sample_threshold, 1 = target_period,
//           other indexes are ignored. cfg_ready is always high.
//   The result is registered in out_r, or in the skid register while the receiver stalls.
//   Throughput: one sample per cycle while in_tready is high; the state update
//   for a sample is a single compare/add stage ahead of the result register.
//   A two-entry output buffer (result register plus skid register) lets one
//   more sample in while a result waits; in_tready drops only when both
//   entries are full, so the input stalls once a sample fills the skid register.
//   Reset (rst_n low, synchronous): duty 400, phase and tick count cleared,
//   threshold 1200, target period 150, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none
module tach_period_duty_regulator_top #(
  parameter int FULL_SCALE = tpdr_pkg::FULL_SCALE_DEF,
  parameter int STEP       = tpdr_pkg::STEP_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [tpdr_pkg::IN_TDATA_W-1:0]    in_tdata,   // [11:0] sample
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [tpdr_pkg::OUT_TDATA_W-1:0]        out_tdata,  // [9:0] duty
  output logic [tpdr_pkg::OUT_TUSER_W-1:0]        out_tuser,  // [0] mark_seen, [1] stall_kick
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tpdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tpdr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tpdr_pkg::*;

  localparam int SUM_W = DUTY_W + 1;
  localparam logic [DUTY_W-1:0] HI_LIM   = DUTY_W'(FULL_SCALE - STEP);
  localparam logic [DUTY_W-1:0] STEP_V   = DUTY_W'(STEP);
  localparam logic [SUM_W-1:0]  KICK_V   = SUM_W'(KICK_STEPS * STEP);

  logic [SAMPLE_W-1:0] threshold_r;
  logic [PERIOD_W-1:0] target_r;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;
  logic                phase_r, phase_nxt;
  logic [TICKS_W-1:0]  ticks_r, ticks_nxt;

  tpdr_result_t out_r, skid_r, res;
  logic         out_valid_r, skid_valid_r;

  logic                in_xfer, out_load;
  logic [SAMPLE_W-1:0] sample;
  logic [TICKS_W-1:0]  ticks_inc;
  logic                above, mark, kick, in_band;
  logic [SUM_W-1:0]    duty_sum;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = !out_valid_r || out_tready;
  assign sample    = in_tdata[SAMPLE_W-1:0];

  always_comb begin
    ticks_inc = ticks_r + TICKS_W'(1);
    above     = sample > threshold_r;
    mark      = above && !phase_r;
    phase_nxt = above;
    in_band   = (duty_r < HI_LIM) && (duty_r > STEP_V);
    kick      = !mark && (ticks_inc == TIMEOUT_TICKS);
    duty_sum  = {1'b0, duty_r};
    if (mark) begin
      if (in_band) begin
        if (ticks_inc > target_r) begin
          duty_sum = {1'b0, duty_r} + {1'b0, STEP_V};
        end else begin
          duty_sum = {1'b0, duty_r} - {1'b0, STEP_V};
        end
      end
    end else if (kick && (duty_r < HI_LIM)) begin
      duty_sum = {1'b0, duty_r} + KICK_V;
    end
    duty_nxt  = duty_sum[DUTY_W] ? DUTY_MAX : duty_sum[DUTY_W-1:0];
    ticks_nxt = (mark || kick) ? '0 : ticks_inc;
    res.duty       = duty_nxt;
    res.mark_seen  = mark;
    res.stall_kick = kick;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      target_r    <= TARGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLE_THRESHOLD: threshold_r <= cfg_data[SAMPLE_W-1:0];
        REG_TARGET_PERIOD:    target_r    <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r  <= DUTY_RESET;
      phase_r <= 1'b0;
      ticks_r <= '0;
    end else if (in_xfer) begin
      duty_r  <= duty_nxt;
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_load) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= in_xfer;
      end else begin
        out_valid_r  <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (in_xfer) begin
          skid_r <= res;
        end
      end else if (in_xfer) begin
        out_r <= res;
      end
    end else if (in_xfer) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_r.duty);
  assign out_tuser  = {out_r.stall_kick, out_r.mark_seen};

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking bench for tach_period_duty_regulator_top: directed table, then
// rotation-shaped random traffic with stalls, checked against an in-bench model.
// Depends on tpdr_pkg and the regulator top level.
`timescale 1ns / 1ps
module tb_top;
  import tpdr_pkg::*;

  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int HI_LIM     = FULL_SCALE_DEF - STEP_DEF;

  localparam logic [CFG_IDX_W-1:0] NO_REG     = REG_SAMPLE_THRESHOLD;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  typed;
    tpdr_result_t          want;
  } dir_row_t;

  localparam int DIR_N = 27;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  logic [SAMPLE_W-1:0] threshold_now;
  logic [PERIOD_W-1:0] target_now;
  logic [DUTY_W-1:0]   duty_now;
  logic                above_now;
  logic [TICKS_W-1:0]  ticks_now;
  tpdr_result_t        last_pred;
  tpdr_result_t        pending_results [$];

  bit idle_on = 1'b1;
  int rx_hold = 0;
  int rx_gap  = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int marks_cnt = 0;
  int kicks_cnt = 0;
  int errors = 0;

  dir_row_t dir_rows [DIR_N] = '{
    {ROW_SAMPLE, NO_REG,               12'd0,    1'b1, 1'b0, 1'b0, 10'd400},
    {ROW_SAMPLE, NO_REG,               12'd1200, 1'b1, 1'b0, 1'b0, 10'd400},
    {ROW_SAMPLE, NO_REG,               12'd1201, 1'b1, 1'b0, 1'b1, 10'd399},
    {ROW_SAMPLE, NO_REG,               12'd4095, 1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd4095, 1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd4095, 1'b0, 12'd0},
    {ROW_CFG,    REG_TARGET_PERIOD,    12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd4095, 1'b0, 12'd0},
    {ROW_CFG,    REG_TARGET_PERIOD,    12'hFFF,  1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd2048, 1'b0, 12'd0},
    {ROW_CFG,    REG_SPARE2,           12'd0,    1'b0, 12'd0},
    {ROW_CFG,    REG_SPARE3,           12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd1200, 1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd1201, 1'b0, 12'd0},
    {ROW_CFG,    REG_SAMPLE_THRESHOLD, 12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd1,    1'b0, 12'd0},
    {ROW_CFG,    REG_SAMPLE_THRESHOLD, 12'd4095, 1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd4095, 1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd0,    1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd4095, 1'b0, 12'd0},
    {ROW_CFG,    REG_SAMPLE_THRESHOLD, 12'd1200, 1'b0, 12'd0},
    {ROW_CFG,    REG_TARGET_PERIOD,    12'd150,  1'b0, 12'd0},
    {ROW_SAMPLE, NO_REG,               12'd2000, 1'b0, 12'd0}
  };

  tach_period_duty_regulator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [11:0] sample
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [9:0] duty
    .out_tuser  (out_tuser),   // [0] mark_seen, [1] stall_kick
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One tick of the regulator: mark detection, period compare, stall timeout.
  function automatic tpdr_result_t regulate_tick(input logic [SAMPLE_W-1:0] smp);
    int cur;
    int nxt;
    int ticks;
    tpdr_result_t res;
    cur   = duty_now;
    nxt   = cur;
    ticks = ticks_now + 1;
    res   = '0;
    if (smp > threshold_now) begin
      if (!above_now) begin
        res.mark_seen = 1'b1;
        if (cur < HI_LIM && cur > STEP_DEF) begin
          nxt = (ticks > target_now) ? cur + STEP_DEF : cur - STEP_DEF;
        end
        ticks     = 0;
        above_now = 1'b1;
      end
    end else begin
      above_now = 1'b0;
    end
    if (ticks == TIMEOUT_TICKS) begin
      res.stall_kick = 1'b1;
      if (cur < HI_LIM) begin
        nxt = cur + KICK_STEPS * STEP_DEF;
      end
      ticks = 0;
    end
    if (nxt > DUTY_MAX) begin
      nxt = DUTY_MAX;
    end
    duty_now  = nxt[DUTY_W-1:0];
    ticks_now = ticks[TICKS_W-1:0];
    res.duty  = duty_now;
    return res;
  endfunction

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input bit typed,
                             input tpdr_result_t want);
    tpdr_result_t pred;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, smp};
    do @(posedge clk); while (!in_tready);
    pred      = regulate_tick(smp);
    last_pred = pred;
    pending_results.push_back(typed ? want : pred);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SAMPLE_THRESHOLD: threshold_now = val[SAMPLE_W-1:0];
      REG_TARGET_PERIOD:    target_now    = val[PERIOD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    for (int w = 0; w < 4000 && pending_results.size() != 0; w++) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Low run then high run: a rotation mark at the first high sample after a low one.
  task automatic spin_rotation(input int lo_n, input int hi_n);
    repeat (lo_n) push_sample(SAMPLE_W'($urandom_range(0, threshold_now)), 1'b0, '0);
    repeat (hi_n) push_sample(SAMPLE_W'($urandom_range(threshold_now + 1, SAMPLE_MAX)),
                              1'b0, '0);
  endtask

  task automatic mixed_traffic(input int n_items);
    int stop;
    int pick;
    int lo_max;
    stop   = samples_sent + n_items;
    lo_max = (target_now > 31) ? 64 : 2 * target_now + 2;
    while (samples_sent < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        spin_rotation($urandom_range(1, lo_max), $urandom_range(1, 6));
      end else if (pick < 9) begin
        push_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0, '0);
      end else begin
        spin_rotation(0, $urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_tready <= 1'b0;
        rx_gap--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        rx_gap = $urandom_range(0, 16);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tpdr_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      marks_cnt += out_tuser[0];
      kicks_cnt += out_tuser[1];
      if (pending_results.size() == 0) begin
        if (errors < 10) begin
          $display("mismatch: unexpected result tdata %h tuser %b", out_tdata, out_tuser);
        end
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (out_tdata !== {{(OUT_TDATA_W-DUTY_W){1'b0}}, exp_res.duty} ||
            out_tuser[0] !== exp_res.mark_seen || out_tuser[1] !== exp_res.stall_kick) begin
          if (errors < 10) begin
            $display("mismatch at %0t: expected duty %0d mark %0b kick %0b",
                     $realtime, exp_res.duty, exp_res.mark_seen, exp_res.stall_kick);
            $display("  got duty %0d mark %0b kick %0b (tdata %h)",
                     out_tdata[DUTY_W-1:0], out_tuser[0], out_tuser[1], out_tdata);
          end
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    threshold_now = THRESHOLD_RESET;
    target_now    = TARGET_RESET;
    duty_now      = DUTY_RESET;
    above_now     = 1'b0;
    ticks_now     = '0;
    last_pred     = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        push_sample(dir_rows[i].val[SAMPLE_W-1:0], dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Regulation around a short target period, with a long receiver hold-off in the first half.
    for (int half = 0; half < 2; half++) begin
      settle();
      write_reg(REG_SAMPLE_THRESHOLD, CFG_DATA_W'($urandom_range(1, SAMPLE_MAX - 1)));
      write_reg(REG_TARGET_PERIOD, CFG_DATA_W'($urandom_range(4, 24)));
      if (half == 0) begin
        rx_hold = 80;
      end
      mixed_traffic(100);
    end

    // Stall with the sample held high: no further mark until the timeout kick.
    push_sample(SAMPLE_W'($urandom_range(0, threshold_now)), 1'b0, '0);
    do push_sample(SAMPLE_W'($urandom_range(threshold_now + 1, SAMPLE_MAX)), 1'b0, '0);
    while (!last_pred.stall_kick);
    repeat (5) spin_rotation(1, 1);

    settle();
    idle_on = 1'b0;
    write_reg(REG_SAMPLE_THRESHOLD, CFG_DATA_W'($urandom_range(1, SAMPLE_MAX - 1)));
    write_reg(REG_TARGET_PERIOD, CFG_DATA_W'($urandom_range(0, 30)));
    mixed_traffic(150);
    settle();

    if (pending_results.size() != 0) begin
      $display("missing %0d results at end of run", pending_results.size());
      errors += pending_results.size();
    end
    $display("summary: %0d samples sent, %0d results checked, %0d marks, %0d stall kicks",
             samples_sent, results_checked, marks_cnt, kicks_cnt);
    $display("summary: thresholds and targets swept to both ends, final duty %0d", duty_now);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tpdr_pkg.sv
src/tach_period_duty_regulator_top.sv
test/tb_top.sv
